// ----- design/lvm_pkg.sv -----
// ----------------------------------------------------------------------------
// LED level meter package
// Shared widths, geometry constants, codes and the per-strip color table.
// ----------------------------------------------------------------------------
`default_nettype none

package lvm_pkg;

   // Display geometry
   localparam int CHANNELS     = 7;
   localparam int STRIP_LENGTH = 18;
   localparam int CENTER       = 9;
   localparam int SAMPLE_BITS  = 12;
   localparam int HALF         = (STRIP_LENGTH > CENTER) ? STRIP_LENGTH - CENTER : 0;

   // Field widths
   localparam int CHANNEL_W   = 3;
   localparam int SAMPLE_W    = 12;
   localparam int STRIP_W     = 4;
   localparam int PIXEL_W     = 5;
   localparam int COLOR_W     = 8;
   localparam int GAIN_W      = 16;
   localparam int CSR_INDEX_W = 1;

   // Internal widths
   localparam int CH_ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PEAK_W    = SAMPLE_BITS;
   localparam int BAR_W     = (HALF > 1) ? $clog2(HALF + 1) : 1;
   localparam int ENTRY_W   = PEAK_W + BAR_W;
   localparam int FRAC_W    = 16;

   typedef enum logic {
      OP_SAMPLE  = 1'b0,
      OP_REFRESH = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ATTACK_GAIN  = 1'b0,
      CSR_DECAY_WEIGHT = 1'b1
   } csr_index_type;

   // One entry of the channel state memory
   typedef struct packed {
      logic [PEAK_W-1:0] peak;
      logic [BAR_W-1:0]  bar;
   } entry_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } color_type;

   // Strip color; dim gives every component divided by ten (truncated)
   function automatic color_type strip_color(input logic [STRIP_W-1:0] strip,
                                             input logic dim);
      color_type c;
      c = '0;
      if (!dim) begin
         unique case (strip)
            4'd0:    c = '{8'd255, 8'd0,   8'd0};
            4'd1:    c = '{8'd200, 8'd0,   8'd55};
            4'd2:    c = '{8'd145, 8'd0,   8'd110};
            4'd3:    c = '{8'd90,  8'd0,   8'd165};
            4'd4:    c = '{8'd35,  8'd0,   8'd220};
            4'd5:    c = '{8'd0,   8'd0,   8'd255};
            4'd6:    c = '{8'd0,   8'd35,  8'd220};
            4'd7:    c = '{8'd0,   8'd70,  8'd185};
            4'd8:    c = '{8'd0,   8'd105, 8'd150};
            4'd9:    c = '{8'd0,   8'd140, 8'd115};
            4'd10:   c = '{8'd0,   8'd175, 8'd80};
            4'd11:   c = '{8'd0,   8'd210, 8'd45};
            4'd12:   c = '{8'd0,   8'd245, 8'd10};
            4'd13:   c = '{8'd0,   8'd255, 8'd0};
            default: c = '{8'd255, 8'd0,   8'd0};
         endcase
      end else begin
         unique case (strip)
            4'd0:    c = '{8'd25, 8'd0,  8'd0};
            4'd1:    c = '{8'd20, 8'd0,  8'd5};
            4'd2:    c = '{8'd14, 8'd0,  8'd11};
            4'd3:    c = '{8'd9,  8'd0,  8'd16};
            4'd4:    c = '{8'd3,  8'd0,  8'd22};
            4'd5:    c = '{8'd0,  8'd0,  8'd25};
            4'd6:    c = '{8'd0,  8'd3,  8'd22};
            4'd7:    c = '{8'd0,  8'd7,  8'd18};
            4'd8:    c = '{8'd0,  8'd10, 8'd15};
            4'd9:    c = '{8'd0,  8'd14, 8'd11};
            4'd10:   c = '{8'd0,  8'd17, 8'd8};
            4'd11:   c = '{8'd0,  8'd21, 8'd4};
            4'd12:   c = '{8'd0,  8'd24, 8'd1};
            4'd13:   c = '{8'd0,  8'd25, 8'd0};
            default: c = '{8'd25, 8'd0,  8'd0};
         endcase
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- design/lvm_req_if.sv -----
// ----------------------------------------------------------------------------
// LED level meter request channel
// Valid/ready channel carrying sample and refresh items.
// ----------------------------------------------------------------------------
`default_nettype none

interface lvm_req_if
   import lvm_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [CHANNEL_W-1:0] channel;
   logic [SAMPLE_W-1:0]  sample;

   modport source (output valid, operation, channel, sample, input ready);
   modport sink   (input valid, operation, channel, sample, output ready);
endinterface

`default_nettype wire

// ----- design/lvm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// LED level meter response channel
// Valid/ready channel carrying pixel writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lvm_rsp_if
   import lvm_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [STRIP_W-1:0] strip;
   logic [PIXEL_W-1:0] pixel;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;
   logic               last;

   modport source (output valid, strip, pixel, red, green, blue, last, input ready);
   modport sink   (input valid, strip, pixel, red, green, blue, last, output ready);
endinterface

`default_nettype wire

// ----- design/lvm_csr_if.sv -----
// ----------------------------------------------------------------------------
// LED level meter configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface lvm_csr_if
   import lvm_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [GAIN_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/lvm_ram.sv -----
// ----------------------------------------------------------------------------
// LED level meter generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- design/led_level_meter_bar_graph.sv -----
// ----------------------------------------------------------------------------
// LED level meter bar graph
// Per-channel peak hold, level smoothing and incremental pixel-write output.
// ----------------------------------------------------------------------------
// The block handles one item at a time; each channel's held peak and bar
// level live in one small state memory with a registered read, so every
// item is a read followed by a write-back. A sample transfer is a read,
// then a compare and write-back of the peak. A refresh is a read, a
// multiply and a sum/clamp/write-back, then one pixel write per cycle
// while the response channel is ready, 2 * 2 * |new - old| writes at most.
// The input is ready again right after the last pixel write is loaded
// into the output register. Reset clears the memory through per-channel
// valid bits, so no clearing pass is needed.
`default_nettype none

module led_level_meter_bar_graph
   import lvm_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   lvm_req_if.sink   req_bus,
   lvm_rsp_if.source rsp_bus,
   lvm_csr_if.sink   csr_bus
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_PRODUCT,
      ST_CALC,
      ST_EMIT
   } state_type;

   localparam int PROD_A_W = GAIN_W + PEAK_W;
   localparam int PROD_B_W = GAIN_W + BAR_W;
   localparam int ACC_W    = PROD_A_W + 1;
   localparam int LVL_W    = ACC_W - FRAC_W;
   localparam logic [PEAK_W-1:0] SAMPLE_MID = PEAK_W'(1 << (SAMPLE_BITS - 1));

   state_type state_ff;

   logic [GAIN_W-1:0] attack_gain_ff;
   logic [GAIN_W-1:0] decay_weight_ff;

   logic [CHANNELS-1:0]  valid_ff;
   logic                 rd_valid_ff;
   logic [CHANNEL_W-1:0] ch_ff;
   logic [PEAK_W-1:0]    sample_ff;
   logic [BAR_W-1:0]     old_ff;
   logic [PROD_A_W-1:0]  prod_a_ff;
   logic [PROD_B_W-1:0]  prod_b_ff;

   // Emission walk
   logic             grow_ff;
   logic [BAR_W-1:0] lo_ff;
   logic [BAR_W-1:0] hi_ff;
   logic [BAR_W-1:0] hi_low_ff;
   logic [BAR_W-1:0] k_ff;
   logic             side_ff;
   logic             tap_ff;

   // Output register
   logic               rsp_valid_ff;
   logic [STRIP_W-1:0] strip_ff;
   logic [PIXEL_W-1:0] pixel_ff;
   color_type          color_ff;
   logic               last_ff;

   // Memory ports
   logic                 wr_en;
   logic [CH_ADDR_W-1:0] wr_addr;
   entry_type            wr_entry;
   logic [ENTRY_W-1:0]   rd_data;
   entry_type            rd_entry;

   logic req_xfer;
   logic ch_ok;

   // Sample path
   logic [PEAK_W-1:0] rect;
   logic [PEAK_W-1:0] new_peak;

   // Refresh path
   logic [ACC_W-1:0]  acc;
   logic [LVL_W-1:0]  lvl;
   logic [BAR_W-1:0]  now_lvl;
   logic [BAR_W-1:0]  lo_in;
   logic [BAR_W-1:0]  hi_in;
   logic [BAR_W-1:0]  hi_low_in;

   // Emission step
   logic               emit;
   logic               side0_end;
   logic               lower_any;
   logic               final_write;
   logic [PIXEL_W-1:0] pixel_in;
   logic [STRIP_W-1:0] strip_in;
   color_type          color_in;

   // Handshakes
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign ch_ok         = (int'(req_bus.channel) < CHANNELS);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.strip = strip_ff;
   assign rsp_bus.pixel = pixel_ff;
   assign rsp_bus.red   = color_ff.red;
   assign rsp_bus.green = color_ff.green;
   assign rsp_bus.blue  = color_ff.blue;
   assign rsp_bus.last  = last_ff;

   // Channel state memory; entries never written read as zero
   lvm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (req_bus.channel[CH_ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rd_entry = rd_valid_ff ? entry_type'(rd_data) : '0;

   // Rectify around mid-scale and raise the peak
   always_comb begin
      rect     = (sample_ff >= SAMPLE_MID) ? sample_ff - SAMPLE_MID
                                           : SAMPLE_MID - sample_ff;
      new_peak = (rect > rd_entry.peak) ? rect : rd_entry.peak;
   end

   // Smoothed level, clamped to the half strip
   always_comb begin
      acc = ACC_W'(prod_a_ff) + ACC_W'(prod_b_ff);
      lvl = acc[ACC_W-1:FRAC_W];
      if (int'(lvl) > HALF) begin
         now_lvl = BAR_W'(HALF);
      end else begin
         now_lvl = lvl[BAR_W-1:0];
      end
      lo_in = (now_lvl > old_ff) ? old_ff : now_lvl;
      hi_in = (now_lvl > old_ff) ? now_lvl : old_ff;
      if (int'(hi_in) > CENTER) begin
         hi_low_in = BAR_W'(CENTER);
      end else begin
         hi_low_in = hi_in;
      end
   end

   // Memory write-back
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = ch_ff[CH_ADDR_W-1:0];
      wr_entry = '0;
      unique case (state_ff)
         ST_SAMPLE: begin
            wr_en    = 1'b1;
            wr_entry = '{peak: new_peak, bar: rd_entry.bar};
         end
         ST_CALC: begin
            wr_en    = 1'b1;
            wr_entry = '{peak: '0, bar: now_lvl};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Next pixel write of the walk
   always_comb begin
      emit        = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_bus.ready);
      side0_end   = !side_ff && (k_ff == hi_ff - BAR_W'(1));
      lower_any   = (lo_ff < hi_low_ff);
      final_write = tap_ff && (side_ff ? (k_ff == hi_low_ff - BAR_W'(1))
                                       : (side0_end && !lower_any));
      if (!side_ff) begin
         pixel_in = PIXEL_W'(CENTER) + PIXEL_W'(k_ff);
      end else begin
         pixel_in = PIXEL_W'(CENTER - 1) - PIXEL_W'(k_ff);
      end
      strip_in = STRIP_W'({ch_ff, tap_ff});
      if (grow_ff) begin
         color_in = strip_color(strip_in, int'(pixel_in) < CENTER);
      end else begin
         color_in = '0;
      end
   end

   // Sequencer, state and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         attack_gain_ff  <= GAIN_W'(204);
         decay_weight_ff <= GAIN_W'(20316);
         valid_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         // Register writes
         if (csr_bus.valid && csr_bus.ready) begin
            unique case (csr_index_type'(csr_bus.index))
               CSR_ATTACK_GAIN:  attack_gain_ff  <= csr_bus.data;
               CSR_DECAY_WEIGHT: decay_weight_ff <= csr_bus.data;
               default:          attack_gain_ff  <= attack_gain_ff;
            endcase
         end

         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end

         // Output valid: loaded by the walk, dropped after a transfer
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer && ch_ok) begin
                  ch_ff       <= req_bus.channel;
                  sample_ff   <= req_bus.sample[PEAK_W-1:0];
                  rd_valid_ff <= valid_ff[req_bus.channel[CH_ADDR_W-1:0]];
                  state_ff    <= (req_bus.operation == OP_REFRESH) ? ST_PRODUCT
                                                                   : ST_SAMPLE;
               end
            end
            ST_SAMPLE: begin
               state_ff <= ST_IDLE;
            end
            ST_PRODUCT: begin
               prod_a_ff <= PROD_A_W'(attack_gain_ff * rd_entry.peak);
               prod_b_ff <= PROD_B_W'(decay_weight_ff * rd_entry.bar);
               old_ff    <= rd_entry.bar;
               state_ff  <= ST_CALC;
            end
            ST_CALC: begin
               grow_ff   <= (now_lvl > old_ff);
               lo_ff     <= lo_in;
               hi_ff     <= hi_in;
               hi_low_ff <= hi_low_in;
               k_ff      <= lo_in;
               side_ff   <= 1'b0;
               tap_ff    <= 1'b0;
               state_ff  <= (now_lvl == old_ff) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
               if (emit) begin
                  strip_ff     <= strip_in;
                  pixel_ff     <= pixel_in;
                  color_ff     <= color_in;
                  last_ff      <= final_write;
                  if (!tap_ff) begin
                     tap_ff <= 1'b1;
                  end else begin
                     tap_ff <= 1'b0;
                     if (side0_end) begin
                        side_ff <= 1'b1;
                        k_ff    <= lo_ff;
                     end else begin
                        k_ff <= k_ff + BAR_W'(1);
                     end
                  end
                  if (final_write) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
